// ===== hw/rtl/lbd_pkg.sv =====
// Shared types, constants and glyph font ROMs for the big-digit LCD renderer.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package lbd_pkg;

  localparam int unsigned DigitLimit = 10;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [6:0] SECOND_LINE   = 7'h40;

  // Configuration register indexes.
  localparam logic CFG_ROW_COUNT    = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  localparam logic [7:0] BLANK = 8'h20;
  localparam logic [7:0] FULL  = 8'hFF;

  localparam logic [7:0] GLYPH3_ROM [10][9] = '{
    '{8'd5, 8'd2, 8'd6, FULL,  BLANK, FULL,  8'd3,  8'd2, 8'd4},
    '{8'd0, FULL, BLANK, BLANK, FULL, BLANK, 8'd2,  8'd2, 8'd2},
    '{8'd0, 8'd2, 8'd6, 8'd5,  8'd2,  8'd4,  8'd3,  8'd2, 8'd4},
    '{8'd0, 8'd2, 8'd6, BLANK, 8'd2,  FULL,  8'd3,  8'd2, 8'd4},
    '{FULL, BLANK, FULL, 8'd3, 8'd2,  FULL,  BLANK, BLANK, 8'd2},
    '{FULL, 8'd2, 8'd4, 8'd2,  8'd2,  8'd6,  8'd3,  8'd2, 8'd4},
    '{8'd5, 8'd2, 8'd1, FULL,  8'd2,  8'd6,  8'd3,  8'd2, 8'd4},
    '{8'd3, 8'd2, FULL, BLANK, 8'd5,  8'd4,  BLANK, 8'd2, BLANK},
    '{8'd5, 8'd2, 8'd6, FULL,  8'd2,  FULL,  8'd3,  8'd2, 8'd4},
    '{8'd5, 8'd2, 8'd6, 8'd3,  8'd2,  FULL,  8'd3,  8'd2, 8'd4}
  };

  localparam logic [7:0] GLYPH2_ROM [10][6] = '{
    '{8'h07, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04},
    '{8'h08, 8'h01, 8'h20, 8'h03, 8'hFF, 8'h03},
    '{8'h05, 8'h05, 8'h01, 8'hFF, 8'h06, 8'h06},
    '{8'h00, 8'h05, 8'h01, 8'h03, 8'h06, 8'h04},
    '{8'h02, 8'h03, 8'hFF, 8'h20, 8'h20, 8'hFF},
    '{8'hFF, 8'h05, 8'h05, 8'h06, 8'h06, 8'h04},
    '{8'h07, 8'h05, 8'h05, 8'h02, 8'h06, 8'h04},
    '{8'h00, 8'h00, 8'h01, 8'h20, 8'h07, 8'h20},
    '{8'h07, 8'h05, 8'h01, 8'h02, 8'h06, 8'h04},
    '{8'h07, 8'h05, 8'h01, 8'h06, 8'h06, 8'h04}
  };

  typedef struct packed {
    logic [3:0] digit;
    logic [2:0] position;
    logic       clock_gaps;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] row_count;
    logic [5:0] column_count;
  } cfg_t;

  // One classified digit: glyph height, font row and the per-row commands.
  typedef struct packed {
    logic [3:0]      digit;
    logic            tall;
    logic [2:0]      addr_en;
    logic [2:0][7:0] addr_cmd;
  } job_t;

  typedef enum logic [1:0] {
    STEP_ADDR,
    STEP_CELL0,
    STEP_CELL1,
    STEP_CELL2
  } step_e;

  function automatic logic [7:0] glyph_cell(logic tall, logic [3:0] digit,
                                            logic [1:0] row, logic [1:0] col);
    logic [3:0] idx;
    idx = {2'b00, row} * 4'd3 + {2'b00, col};
    return tall ? GLYPH3_ROM[digit][idx] : GLYPH2_ROM[digit][idx[2:0]];
  endfunction

endpackage

// ===== hw/rtl/lbd_front.sv =====
// Front end: configuration registers, input acceptance and digit classification.
// Depends on lbd_pkg; feeds jobs into lbd_queue.
`timescale 1ns / 1ps

module lbd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [5:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lbd_pkg::in_item_t in_data_i,
  output logic             push_o,
  output lbd_pkg::job_t    job_o,
  input  logic             full_i
);

  lbd_pkg::cfg_t cfg_q, cfg_d;
  logic [4:0]    col_base, col_gap1, column;
  logic          col_ok;
  logic [6:0]    row_off [3];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lbd_pkg::CFG_ROW_COUNT:    cfg_d.row_count    = cfg_data_i[2:0];
        lbd_pkg::CFG_COLUMN_COUNT: cfg_d.column_count = cfg_data_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count    <= 3'd2;
      cfg_q.column_count <= 6'd16;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Base column with the optional clock-layout gaps.
  always_comb begin
    col_base = {2'b00, in_data_i.position} * 5'd3;
    col_gap1 = (in_data_i.clock_gaps && col_base >= 5'd6) ? col_base + 5'd1 : col_base;
    column   = (in_data_i.clock_gaps && col_gap1 >= 5'd12) ? col_gap1 + 5'd1 : col_gap1;
    col_ok   = {1'b0, column} < cfg_q.column_count;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_off[r] = 7'd0;
      if (cfg_q.row_count == 3'd2) begin
        if (r == 1) row_off[r] = lbd_pkg::SECOND_LINE;
      end else if (cfg_q.row_count == 3'd4) begin
        row_off[r] = ((r % 2) == 1) ? lbd_pkg::SECOND_LINE : 7'd0;
        if (r >= 2) row_off[r] = row_off[r] + {1'b0, cfg_q.column_count};
      end
    end
  end

  always_comb begin
    job_o.digit = in_data_i.digit;
    job_o.tall  = cfg_q.row_count > 3'd2;
    for (int r = 0; r < 3; r++) begin
      job_o.addr_en[r]  = col_ok && (3'(r) < cfg_q.row_count);
      job_o.addr_cmd[r] = lbd_pkg::CMD_SET_DDRAM |
                          ({1'b0, row_off[r]} + {3'b000, column});
    end
  end

  // Digits ten and above are taken and dropped without a job.
  assign push_o = in_valid_i && !full_i && (in_data_i.digit < 4'(lbd_pkg::DigitLimit));

endmodule

// ===== hw/rtl/lbd_queue.sv =====
// Two-entry job queue between the front end and the write sequencer.
// Depends on lbd_pkg for the job type.
`timescale 1ns / 1ps

module lbd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lbd_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  output lbd_pkg::job_t job_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = $clog2(lbd_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(lbd_pkg::QueueDepth + 1);

  lbd_pkg::job_t  mem_q [lbd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(lbd_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(lbd_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(lbd_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== hw/rtl/lbd_back.sv =====
// Write sequencer: walks glyph rows and cells of one job and drives the output register.
// Depends on lbd_pkg for the job type, step encoding and font ROMs.
`timescale 1ns / 1ps

module lbd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  lbd_pkg::job_t     job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lbd_pkg::out_item_t out_data_o
);

  lbd_pkg::job_t      cur_q, cur_d;
  logic               busy_q, busy_d;
  logic [1:0]         row_q, row_d;
  lbd_pkg::step_e     step_q, step_d;
  lbd_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               advance, emit, fin;
  logic [1:0]         last_row;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign advance     = !out_valid_q || out_ready_i;
  assign emit        = busy_q && advance;
  assign last_row    = cur_q.tall ? 2'd2 : 2'd1;
  assign fin         = (step_q == lbd_pkg::STEP_CELL2) && (row_q == last_row);

  always_comb begin
    cur_d       = cur_q;
    busy_d      = busy_q;
    row_d       = row_q;
    step_d      = step_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (emit) begin
      out_valid_d = 1'b1;
      unique case (step_q)
        lbd_pkg::STEP_ADDR: begin
          out_d.lcd_byte = cur_q.addr_cmd[row_q];
          out_d.is_data  = 1'b0;
          out_d.last     = 1'b0;
          step_d         = lbd_pkg::STEP_CELL0;
        end
        lbd_pkg::STEP_CELL0, lbd_pkg::STEP_CELL1: begin
          out_d.lcd_byte = lbd_pkg::glyph_cell(cur_q.tall, cur_q.digit, row_q,
                                               2'(step_q) - 2'd1);
          out_d.is_data  = 1'b1;
          out_d.last     = 1'b0;
          step_d         = (step_q == lbd_pkg::STEP_CELL0) ? lbd_pkg::STEP_CELL1
                                                           : lbd_pkg::STEP_CELL2;
        end
        lbd_pkg::STEP_CELL2: begin
          out_d.lcd_byte = lbd_pkg::glyph_cell(cur_q.tall, cur_q.digit, row_q, 2'd2);
          out_d.is_data  = 1'b1;
          out_d.last     = fin;
          if (fin) begin
            busy_d = 1'b0;
          end else begin
            row_d  = row_q + 2'd1;
            step_d = cur_q.addr_en[row_q + 2'd1] ? lbd_pkg::STEP_ADDR
                                                 : lbd_pkg::STEP_CELL0;
          end
        end
        default: step_d = lbd_pkg::STEP_ADDR;
      endcase
    end

    // The next job is loaded in the same cycle the current one finishes.
    if (job_valid_i && (!busy_q || (emit && fin))) begin
      pop_o  = 1'b1;
      cur_d  = job_i;
      busy_d = 1'b1;
      row_d  = 2'd0;
      step_d = job_i.addr_en[0] ? lbd_pkg::STEP_ADDR : lbd_pkg::STEP_CELL0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      row_q       <= 2'd0;
      step_q      <= lbd_pkg::STEP_ADDR;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      row_q       <= row_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

endmodule

// ===== hw/rtl/lcd_big_digit_renderer_top.sv =====
// Throughput: one write per cycle from the sequencer while out_ready_i is high, 6 to 12
// writes per digit (three cells per glyph row plus an optional address command per row);
// digits ten and above produce nothing. A two-entry job queue lets input keep flowing.
// Reset: row_count returns to 2, column_count to 16, queue and output register empty.
// Top level; instantiates lbd_front, lbd_queue and lbd_back, uses lbd_pkg types.
`timescale 1ns / 1ps

module lcd_big_digit_renderer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lbd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lbd_pkg::out_item_t out_data_o
);

  logic          push, full, job_valid, pop;
  lbd_pkg::job_t job_in, job_out;

  lbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .job_o       (job_in),
    .full_i      (full)
  );

  lbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .valid_o (job_valid),
    .job_o   (job_out),
    .pop_i   (pop)
  );

  lbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
